// ----- rtl/mrd_pkg.sv -----
// Shared types, codes and the CRC-16 byte update for the Modbus RTU response deframer.
package mrd_pkg;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  localparam logic RK_WORD   = 1'b0;
  localparam logic RK_STATUS = 1'b1;

  localparam logic [1:0] FS_OK        = 2'd0;
  localparam logic [1:0] FS_CRC_ERR   = 2'd1;
  localparam logic [1:0] FS_EXCEPTION = 2'd2;
  localparam logic [1:0] FS_CUT_SHORT = 2'd3;

  localparam logic [1:0] WM_BYTE = 2'd0;
  localparam logic [1:0] WM_HALF = 2'd1;
  localparam logic [1:0] WM_WORD = 2'd2;
  localparam logic [1:0] WM_RESET = WM_HALF;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       frame_start;
  } in_beat_t;

  typedef struct packed {
    logic               result_kind;
    logic signed [31:0] word_value;
    logic [1:0]         frame_status;
    logic [7:0]         slave_address;
    logic [7:0]         function_code;
    logic [7:0]         word_count;
    logic               last;
  } result_t;

  function automatic logic [15:0] crc16_byte(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// ----- rtl/mrd_ifs.sv -----
// Channel interfaces: input bytes, results and the word mode write port.
interface mrd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       frame_start;
  modport source (output valid, rx_byte, frame_start, input ready);
  modport sink (input valid, rx_byte, frame_start, output ready);
endinterface

interface mrd_out_if;
  logic               valid;
  logic               ready;
  logic               result_kind;
  logic signed [31:0] word_value;
  logic [1:0]         frame_status;
  logic [7:0]         slave_address;
  logic [7:0]         function_code;
  logic [7:0]         word_count;
  logic               last;
  modport source (output valid, result_kind, word_value, frame_status, slave_address,
                  function_code, word_count, last, input ready);
  modport sink (input valid, result_kind, word_value, frame_status, slave_address,
                function_code, word_count, last, output ready);
endinterface

interface mrd_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] word_mode;
  modport source (output valid, word_mode, input ready);
  modport sink (input valid, word_mode, output ready);
endinterface

// ----- rtl/mrd_in_reg.sv -----
// Input register: holds one byte beat ahead of the frame engine.
module mrd_in_reg
  import mrd_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  in_beat_t in_beat,
  output logic     in_ready,
  input  logic     adv,
  output logic     s1_valid,
  output in_beat_t s1_beat
);

  logic     s1_valid_r;
  logic     s1_valid_nxt;
  in_beat_t s1_beat_r;

  assign in_ready = !s1_valid_r || adv;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_ready) begin
      s1_valid_nxt = in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_beat_r <= in_beat;
    end
  end

  assign s1_valid = s1_valid_r;
  assign s1_beat  = s1_beat_r;

endmodule

// ----- rtl/mrd_engine.sv -----
// Frame engine: phase tracking, running CRC, word packing and status generation.
module mrd_engine
  import mrd_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     cfg_valid,
  input  logic [1:0] cfg_word_mode,
  input  logic     s1_valid,
  input  in_beat_t s1_beat,
  input  logic     out_free,
  output logic     adv,
  output logic     emit,
  output result_t  res
);

  localparam logic [2:0] PH_ADDR   = 3'd0;
  localparam logic [2:0] PH_FUNC   = 3'd1;
  localparam logic [2:0] PH_COUNT  = 3'd2;
  localparam logic [2:0] PH_DATA   = 3'd3;
  localparam logic [2:0] PH_CRC_LO = 3'd4;
  localparam logic [2:0] PH_CRC_HI = 3'd5;

  logic [1:0]  mode_r;
  logic [2:0]  phase_r, phase_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic [7:0]  exp_r, exp_nxt;
  logic [7:0]  seen_r, seen_nxt;
  logic [31:0] acc_r, acc_nxt;
  logic [1:0]  biw_r, biw_nxt;
  logic [7:0]  addr_r, addr_nxt;
  logic [7:0]  func_r, func_nxt;
  logic [7:0]  crc_lo_r, crc_lo_nxt;
  logic [7:0]  cnt_r, cnt_nxt;

  logic [7:0]  b;
  logic [15:0] crc_upd;
  logic [31:0] acc_shift;
  logic [7:0]  seen_inc;
  logic [2:0]  k;
  logic [2:0]  size;
  logic [1:0]  pad;
  logic [31:0] pad_v;
  logic [31:0] word_v;
  logic        last_byte;
  logic        in_frame;

  assign b         = s1_beat.rx_byte;
  assign crc_upd   = crc16_byte(crc_r, b);
  assign acc_shift = {acc_r[23:0], b};
  assign seen_inc  = seen_r + 8'd1;
  assign k         = {1'b0, biw_r} + 3'd1;
  assign last_byte = seen_inc >= exp_r;
  assign in_frame  = (phase_r >= PH_FUNC) && (phase_r <= PH_CRC_HI);

  always_comb begin
    unique case (mode_r)
      WM_BYTE: size = 3'd1;
      WM_HALF: size = 3'd2;
      default: size = 3'd4;
    endcase
  end

  // Pad a short final word with zero bytes at the low end.
  assign pad = (k >= size) ? 2'd0 : 2'(size - k);

  always_comb begin
    unique case (pad)
      2'd0: pad_v = acc_shift;
      2'd1: pad_v = {acc_shift[23:0], 8'h00};
      2'd2: pad_v = {acc_shift[15:0], 16'h0000};
      default: pad_v = {acc_shift[7:0], 24'h000000};
    endcase
  end

  always_comb begin
    unique case (size)
      3'd1: word_v = {24'h000000, pad_v[7:0]};
      3'd2: word_v = {{16{pad_v[15]}}, pad_v[15:0]};
      default: word_v = pad_v;
    endcase
  end

  always_comb begin
    phase_nxt  = phase_r;
    crc_nxt    = crc_r;
    exp_nxt    = exp_r;
    seen_nxt   = seen_r;
    acc_nxt    = acc_r;
    biw_nxt    = biw_r;
    addr_nxt   = addr_r;
    func_nxt   = func_r;
    crc_lo_nxt = crc_lo_r;
    cnt_nxt    = cnt_r;
    emit       = 1'b0;
    res        = '0;
    res.slave_address = addr_r;
    res.function_code = func_r;

    if (s1_beat.frame_start) begin
      // Close an unfinished frame, then open the new one.
      if (in_frame) begin
        emit             = 1'b1;
        res.result_kind  = RK_STATUS;
        res.frame_status = FS_CUT_SHORT;
        res.word_count   = cnt_r;
        res.last         = 1'b1;
      end
      crc_nxt    = crc16_byte(CRC_INIT, b);
      addr_nxt   = b;
      func_nxt   = 8'h00;
      exp_nxt    = 8'h00;
      seen_nxt   = 8'h00;
      acc_nxt    = 32'h0;
      biw_nxt    = 2'd0;
      crc_lo_nxt = 8'h00;
      cnt_nxt    = 8'h00;
      phase_nxt  = PH_FUNC;
    end else begin
      unique case (phase_r)
        PH_FUNC: begin
          func_nxt  = b;
          crc_nxt   = crc_upd;
          phase_nxt = PH_COUNT;
        end
        PH_COUNT: begin
          crc_nxt  = crc_upd;
          seen_nxt = 8'h00;
          if (func_r[7] || (b == 8'h00)) begin
            exp_nxt   = 8'h00;
            phase_nxt = PH_CRC_LO;
          end else begin
            exp_nxt   = b;
            phase_nxt = PH_DATA;
          end
        end
        PH_DATA: begin
          crc_nxt   = crc_upd;
          seen_nxt  = seen_inc;
          phase_nxt = last_byte ? PH_CRC_LO : PH_DATA;
          if ((k >= size) || last_byte) begin
            emit            = 1'b1;
            res.result_kind = RK_WORD;
            res.word_value  = word_v;
            acc_nxt         = 32'h0;
            biw_nxt         = 2'd0;
            cnt_nxt         = cnt_r + 8'd1;
          end else begin
            acc_nxt = acc_shift;
            biw_nxt = k[1:0];
          end
        end
        PH_CRC_LO: begin
          crc_lo_nxt = b;
          phase_nxt  = PH_CRC_HI;
        end
        PH_CRC_HI: begin
          emit            = 1'b1;
          res.result_kind = RK_STATUS;
          res.word_count  = cnt_r;
          res.last        = 1'b1;
          if ({b, crc_lo_r} != crc_r) begin
            res.frame_status = FS_CRC_ERR;
          end else if (func_r[7]) begin
            res.frame_status = FS_EXCEPTION;
          end else begin
            res.frame_status = FS_OK;
          end
          phase_nxt = PH_ADDR;
        end
        default: begin
          // Drop stray bytes between frames.
          phase_nxt = PH_ADDR;
        end
      endcase
    end
  end

  assign adv = s1_valid && (!emit || out_free);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= WM_RESET;
    end else if (cfg_valid) begin
      mode_r <= cfg_word_mode;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_ADDR;
      crc_r    <= CRC_INIT;
      exp_r    <= 8'h00;
      seen_r   <= 8'h00;
      acc_r    <= 32'h0;
      biw_r    <= 2'd0;
      addr_r   <= 8'h00;
      func_r   <= 8'h00;
      crc_lo_r <= 8'h00;
      cnt_r    <= 8'h00;
    end else if (adv) begin
      phase_r  <= phase_nxt;
      crc_r    <= crc_nxt;
      exp_r    <= exp_nxt;
      seen_r   <= seen_nxt;
      acc_r    <= acc_nxt;
      biw_r    <= biw_nxt;
      addr_r   <= addr_nxt;
      func_r   <= func_nxt;
      crc_lo_r <= crc_lo_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

// ----- rtl/mrd_out_reg.sv -----
// Result register: holds one result beat until the sink takes it.
module mrd_out_reg
  import mrd_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    load,
  input  result_t res,
  output logic    out_free,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_res
);

  logic    out_valid_r;
  logic    out_valid_nxt;
  result_t out_res_r;

  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_free) begin
      out_valid_nxt = load;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && load) begin
      out_res_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

endmodule

// ----- rtl/modbus_rtu_response_deframer_core.sv -----
// A byte accepted into the input register shows its result from the result register.
// Throughput: one byte per cycle; a byte waits only while a result is held in a stalled
// result register. The per-byte CRC update and word packing sit between the two registers.
// Reset (rst_n low, synchronous): waits for a frame start, CRC 0xFFFF, word mode 1,
// both registers empty. The word mode port is always ready.
// Top level: Modbus RTU response deframer with CRC check and word packing.
module modbus_rtu_response_deframer_core
  import mrd_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  mrd_in_if.sink           in_bus,
  mrd_out_if.source        out_bus,
  mrd_cfg_if.sink          cfg_bus
);

  in_beat_t in_beat;
  in_beat_t s1_beat;
  logic     s1_valid;
  logic     adv;
  logic     emit;
  logic     out_free;
  result_t  res;
  result_t  out_res;

  assign in_beat.rx_byte     = in_bus.rx_byte;
  assign in_beat.frame_start = in_bus.frame_start;
  assign cfg_bus.ready       = 1'b1;

  mrd_in_reg u_in_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_bus.valid),
    .in_beat  (in_beat),
    .in_ready (in_bus.ready),
    .adv      (adv),
    .s1_valid (s1_valid),
    .s1_beat  (s1_beat)
  );

  mrd_engine u_engine (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_valid     (cfg_bus.valid),
    .cfg_word_mode (cfg_bus.word_mode),
    .s1_valid      (s1_valid),
    .s1_beat       (s1_beat),
    .out_free      (out_free),
    .adv           (adv),
    .emit          (emit),
    .res           (res)
  );

  mrd_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (adv && emit),
    .res       (res),
    .out_free  (out_free),
    .out_valid (out_bus.valid),
    .out_ready (out_bus.ready),
    .out_res   (out_res)
  );

  assign out_bus.result_kind   = out_res.result_kind;
  assign out_bus.word_value    = out_res.word_value;
  assign out_bus.frame_status  = out_res.frame_status;
  assign out_bus.slave_address = out_res.slave_address;
  assign out_bus.function_code = out_res.function_code;
  assign out_bus.word_count    = out_res.word_count;
  assign out_bus.last          = out_res.last;

endmodule

// ----- rtl/mrd_checker.sv -----
// Port-level checker for the deframer result channel, bound to the top level.
module mrd_checker
  import mrd_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_ready,
  input logic               result_kind,
  input logic signed [31:0] word_value,
  input logic [1:0]         frame_status,
  input logic [7:0]         word_count,
  input logic               last
);

  // A stalled result beat holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(word_value) && $stable(result_kind))
    else $error("result beat changed while stalled");

  a_word_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (result_kind == RK_WORD) |-> !last && (word_count == 8'd0)
      && (frame_status == FS_OK))
    else $error("data word carries status fields");

  a_status_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (result_kind == RK_STATUS) |-> last && (word_value == 32'sd0))
    else $error("status result malformed");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind modbus_rtu_response_deframer_core mrd_checker u_mrd_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_bus.valid),
  .out_ready    (out_bus.ready),
  .result_kind  (out_bus.result_kind),
  .word_value   (out_bus.word_value),
  .frame_status (out_bus.frame_status),
  .word_count   (out_bus.word_count),
  .last         (out_bus.last)
);

// ----- tb/testbench.sv -----
// Self-checking bench for the Modbus RTU response deframer: directed frames, then random traffic.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import mrd_pkg::*;

  localparam int NUM_ROWS        = 26;
  localparam int NUM_PHASES      = 11;
  localparam int ITEMS_PER_PHASE = 100;
  localparam int QUIET_LIMIT     = 2000;
  localparam int DRAIN_CYCLES    = 4;
  localparam int LONG_HOLD       = 120;
  localparam int MAX_PRINTS      = 50;

  // decodes as 32-bit words
  localparam logic [1:0] WM_SPARE = 2'd3;

  typedef enum logic [2:0] {
    PH_ADDR, PH_FUNC, PH_COUNT, PH_DATA, PH_CRC_LO, PH_CRC_HI
  } deframe_phase_e;

  // how a planned byte gets its value from the running checksum
  typedef enum logic [2:0] {
    CP_NONE, CP_LO, CP_HI, CP_LO_BAD, CP_HI_BAD
  } crc_pick_e;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       frame_start;
    crc_pick_e  pick;
    logic       typed;
    logic [1:0] want_status;
    logic [7:0] want_addr;
    logic [7:0] want_func;
    logic [7:0] want_count;
  } rx_plan_t;

  // byte, start, checksum pick, typed, status, address, function, word count
  localparam rx_plan_t DIRECTED_ROWS [NUM_ROWS] = '{
    '{8'h55, 1'b0, CP_NONE, 1'b0, FS_OK,        8'h00, 8'h00, 8'h00},
    '{8'h01, 1'b1, CP_NONE, 1'b0, FS_OK,        8'h00, 8'h00, 8'h00},
    '{8'h83, 1'b0, CP_NONE, 1'b0, FS_OK,        8'h00, 8'h00, 8'h00},
    '{8'h03, 1'b0, CP_NONE, 1'b0, FS_OK,        8'h00, 8'h00, 8'h00},
    '{8'h01, 1'b0, CP_NONE, 1'b0, FS_OK,        8'h00, 8'h00, 8'h00},
    '{8'h31, 1'b0, CP_NONE, 1'b1, FS_EXCEPTION, 8'h01, 8'h83, 8'h00},
    '{8'h01, 1'b1, CP_NONE, 1'b0, FS_OK,        8'h00, 8'h00, 8'h00},
    '{8'h83, 1'b0, CP_NONE, 1'b0, FS_OK,        8'h00, 8'h00, 8'h00},
    '{8'h03, 1'b0, CP_NONE, 1'b0, FS_OK,        8'h00, 8'h00, 8'h00},
    '{8'h01, 1'b0, CP_NONE, 1'b0, FS_OK,        8'h00, 8'h00, 8'h00},
    '{8'h30, 1'b0, CP_NONE, 1'b1, FS_CRC_ERR,   8'h01, 8'h83, 8'h00},
    '{8'hFF, 1'b1, CP_NONE, 1'b0, FS_OK,        8'h00, 8'h00, 8'h00},
    '{8'h03, 1'b0, CP_NONE, 1'b0, FS_OK,        8'h00, 8'h00, 8'h00},
    '{8'h03, 1'b0, CP_NONE, 1'b0, FS_OK,        8'h00, 8'h00, 8'h00},
    '{8'h80, 1'b0, CP_NONE, 1'b0, FS_OK,        8'h00, 8'h00, 8'h00},
    '{8'h00, 1'b0, CP_NONE, 1'b0, FS_OK,        8'h00, 8'h00, 8'h00},
    '{8'hFF, 1'b0, CP_NONE, 1'b0, FS_OK,        8'h00, 8'h00, 8'h00},
    '{8'h00, 1'b0, CP_LO,   1'b0, FS_OK,        8'h00, 8'h00, 8'h00},
    '{8'h00, 1'b0, CP_HI,   1'b0, FS_OK,        8'h00, 8'h00, 8'h00},
    '{8'h11, 1'b1, CP_NONE, 1'b0, FS_OK,        8'h00, 8'h00, 8'h00},
    '{8'h03, 1'b0, CP_NONE, 1'b0, FS_OK,        8'h00, 8'h00, 8'h00},
    '{8'h00, 1'b1, CP_NONE, 1'b1, FS_CUT_SHORT, 8'h11, 8'h03, 8'h00},
    '{8'h04, 1'b0, CP_NONE, 1'b0, FS_OK,        8'h00, 8'h00, 8'h00},
    '{8'h00, 1'b0, CP_NONE, 1'b0, FS_OK,        8'h00, 8'h00, 8'h00},
    '{8'h00, 1'b0, CP_LO,   1'b0, FS_OK,        8'h00, 8'h00, 8'h00},
    '{8'h00, 1'b0, CP_HI,   1'b0, FS_OK,        8'h00, 8'h00, 8'h00}
  };

  logic clk;
  logic rst_n;

  mrd_in_if  in_bus ();
  mrd_out_if out_bus ();
  mrd_cfg_if cfg_bus ();

  modbus_rtu_response_deframer_core dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .out_bus (out_bus),
    .cfg_bus (cfg_bus)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // shadow copy of the deframer state
  deframe_phase_e shadow_phase;
  logic [15:0]    shadow_crc;
  logic [7:0]     shadow_expect_len;
  logic [7:0]     shadow_seen;
  logic [31:0]    shadow_acc;
  logic [1:0]     shadow_pos;
  logic [7:0]     shadow_addr;
  logic [7:0]     shadow_func;
  logic [7:0]     shadow_crc_lo;
  logic [7:0]     shadow_words;
  logic [1:0]     shadow_mode;

  result_t  frame_results_q [$];
  rx_plan_t byte_plan [$];

  int  mismatches;
  int  results_seen;
  int  quiet_cycles;
  int  hold_request;
  int  stall_left;
  bit  steady_in;
  bit  steady_out;

  function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] data);
    logic [15:0] c;
    c = crc;
    for (int i = 0; i < 8; i++) begin
      if (c[0] ^ data[i]) c = {1'b0, c[15:1]} ^ CRC_POLY;
      else c = {1'b0, c[15:1]};
    end
    return c;
  endfunction

  function automatic result_t status_result(input logic [1:0] st);
    result_t r;
    r = '0;
    r.result_kind   = RK_STATUS;
    r.frame_status  = st;
    r.slave_address = shadow_addr;
    r.function_code = shadow_func;
    r.word_count    = shadow_words;
    r.last          = 1'b1;
    return r;
  endfunction

  // close the current word; pad a short one with zero bytes at the low end
  function automatic result_t data_result(input int unsigned size, input logic [2:0] k);
    result_t     r;
    logic [31:0] v;
    v = shadow_acc;
    if (k < size) v = v << (8 * (size - k));
    if (size == 1) v = {24'h0, v[7:0]};
    else if (size == 2) v = {{16{v[15]}}, v[15:0]};
    r = '0;
    r.result_kind   = RK_WORD;
    r.word_value    = v;
    r.slave_address = shadow_addr;
    r.function_code = shadow_func;
    shadow_words = shadow_words + 8'd1;
    shadow_acc   = '0;
    shadow_pos   = '0;
    return r;
  endfunction

  function automatic bit deframe_byte(input in_beat_t b, output result_t r);
    logic [2:0]  k;
    int unsigned size;
    bit          cut;
    logic [1:0]  st;
    r = '0;
    if (b.frame_start) begin
      cut = (shadow_phase != PH_ADDR);
      if (cut) r = status_result(FS_CUT_SHORT);
      shadow_crc        = crc_step(CRC_INIT, b.rx_byte);
      shadow_addr       = b.rx_byte;
      shadow_func       = '0;
      shadow_expect_len = '0;
      shadow_seen       = '0;
      shadow_acc        = '0;
      shadow_pos        = '0;
      shadow_crc_lo     = '0;
      shadow_words      = '0;
      shadow_phase      = PH_FUNC;
      return cut;
    end
    case (shadow_phase)
      PH_FUNC: begin
        shadow_func  = b.rx_byte;
        shadow_crc   = crc_step(shadow_crc, b.rx_byte);
        shadow_phase = PH_COUNT;
        return 0;
      end
      PH_COUNT: begin
        shadow_crc = crc_step(shadow_crc, b.rx_byte);
        // exception: third byte is the code, checksum follows; a zero byte count also goes to the checksum
        if (shadow_func[7] || b.rx_byte == 8'h00) begin
          shadow_expect_len = '0;
          shadow_phase      = PH_CRC_LO;
        end else begin
          shadow_expect_len = b.rx_byte;
          shadow_phase      = PH_DATA;
        end
        shadow_seen = '0;
        return 0;
      end
      PH_DATA: begin
        shadow_crc  = crc_step(shadow_crc, b.rx_byte);
        shadow_acc  = {shadow_acc[23:0], b.rx_byte};
        shadow_seen = shadow_seen + 8'd1;
        k           = {1'b0, shadow_pos} + 3'd1;
        shadow_pos  = k[1:0];
        // the spare mode falls through to 32-bit
        size = (shadow_mode == WM_BYTE) ? 1 : (shadow_mode == WM_HALF) ? 2 : 4;
        if (shadow_seen >= shadow_expect_len) shadow_phase = PH_CRC_LO;
        if (k >= size) begin
          r = data_result(size, 3'(size));
          return 1;
        end
        if (shadow_phase == PH_CRC_LO) begin
          r = data_result(size, k);
          return 1;
        end
        return 0;
      end
      PH_CRC_LO: begin
        shadow_crc_lo = b.rx_byte;
        shadow_phase  = PH_CRC_HI;
        return 0;
      end
      PH_CRC_HI: begin
        if ({b.rx_byte, shadow_crc_lo} != shadow_crc) st = FS_CRC_ERR;
        else if (shadow_func[7]) st = FS_EXCEPTION;
        else st = FS_OK;
        r = status_result(st);
        shadow_phase = PH_ADDR;
        return 1;
      end
      default: begin
        shadow_phase = PH_ADDR;
        return 0;
      end
    endcase
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= MAX_PRINTS) $display("mismatch at %0t ns: %s", $realtime, msg);
  endtask

  // Called at a falling edge; returns at the falling edge after the beat is taken.
  task automatic send_beat(input rx_plan_t s);
    in_beat_t b;
    result_t  r;
    int       gap;
    gap = steady_in ? 0 : pick_gap();
    if (gap > 0) begin
      in_bus.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    b.rx_byte     = s.rx_byte;
    b.frame_start = s.frame_start;
    case (s.pick)
      CP_LO:     b.rx_byte = shadow_crc[7:0];
      CP_HI:     b.rx_byte = shadow_crc[15:8];
      CP_LO_BAD: b.rx_byte = shadow_crc[7:0] ^ (8'h01 << $urandom_range(0, 7));
      CP_HI_BAD: b.rx_byte = shadow_crc[15:8] ^ (8'h01 << $urandom_range(0, 7));
      default: ;
    endcase
    in_bus.rx_byte     = b.rx_byte;
    in_bus.frame_start = b.frame_start;
    in_bus.valid       = 1'b1;
    do @(posedge clk); while (!in_bus.ready);
    if (deframe_byte(b, r) && !s.typed) frame_results_q.push_back(r);
    if (s.typed) begin
      r = '0;
      r.result_kind   = RK_STATUS;
      r.frame_status  = s.want_status;
      r.slave_address = s.want_addr;
      r.function_code = s.want_func;
      r.word_count    = s.want_count;
      r.last          = 1'b1;
      frame_results_q.push_back(r);
    end
    @(negedge clk);
  endtask

  // Called at a falling edge; drop valid, let every result come out, settle.
  task automatic wait_idle();
    in_bus.valid = 1'b0;
    while (frame_results_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic set_word_mode(input logic [1:0] mode);
    cfg_bus.word_mode = mode;
    cfg_bus.valid     = 1'b1;
    do @(posedge clk); while (!cfg_bus.ready);
    shadow_mode = mode;
    @(negedge clk);
    cfg_bus.valid = 1'b0;
  endtask

  // Queue one response frame, sometimes after stray bytes: mostly well formed, some cut short or with a bad checksum.
  task automatic plan_frame();
    rx_plan_t   s;
    rx_plan_t   frame [$];
    logic [7:0] fn;
    logic [7:0] cnt;
    int         r;
    int         keep;
    s = '0;
    if ($urandom_range(0, 99) < 6) begin
      repeat ($urandom_range(1, 3)) begin
        s.rx_byte = 8'($urandom_range(0, 255));
        byte_plan.push_back(s);
      end
    end
    s.rx_byte     = 8'($urandom_range(0, 255));
    s.frame_start = 1'b1;
    frame.push_back(s);
    s.frame_start = 1'b0;
    r = $urandom_range(0, 99);
    if (r < 15) fn = 8'h80 | 8'($urandom_range(0, 127));
    else if (r < 60) fn = 8'h03;
    else if (r < 75) fn = 8'h04;
    else fn = 8'($urandom_range(0, 127));
    s.rx_byte = fn;
    frame.push_back(s);
    r = $urandom_range(0, 99);
    if (fn[7]) cnt = 8'($urandom_range(0, 255));
    else if (r < 4) cnt = 8'($urandom_range(128, 255));
    else if (r < 12) cnt = 8'h00;
    else cnt = 8'($urandom_range(1, 12));
    s.rx_byte = cnt;
    frame.push_back(s);
    if (!fn[7]) begin
      for (int i = 0; i < cnt; i++) begin
        s.rx_byte = 8'($urandom_range(0, 255));
        frame.push_back(s);
      end
    end
    r = $urandom_range(0, 99);
    s.rx_byte = 8'h00;
    s.pick    = (r < 6) ? CP_LO_BAD : CP_LO;
    frame.push_back(s);
    s.pick = (r >= 6 && r < 12) ? CP_HI_BAD : CP_HI;
    frame.push_back(s);
    keep = frame.size();
    if ($urandom_range(0, 99) < 8) keep = $urandom_range(1, frame.size() - 1);
    for (int i = 0; i < keep; i++) byte_plan.push_back(frame[i]);
  endtask

  // result side: random stalls, plus one long hold on request
  initial begin
    out_bus.ready = 1'b0;
    stall_left    = 0;
    forever begin
      @(negedge clk);
      if (hold_request > 0) begin
        stall_left   = hold_request;
        hold_request = 0;
      end
      if (stall_left > 0) begin
        out_bus.ready = 1'b0;
        stall_left--;
      end else begin
        out_bus.ready = 1'b1;
        if (!steady_out && $urandom_range(0, 99) < 25) stall_left = pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      got.result_kind   = out_bus.result_kind;
      got.word_value    = out_bus.word_value;
      got.frame_status  = out_bus.frame_status;
      got.slave_address = out_bus.slave_address;
      got.function_code = out_bus.function_code;
      got.word_count    = out_bus.word_count;
      got.last          = out_bus.last;
      results_seen++;
      if (frame_results_q.size() == 0) begin
        report_mismatch($sformatf("beat %0d arrived with none expected: kind %0d value %h",
                                  results_seen, got.result_kind, got.word_value));
      end else begin
        want = frame_results_q.pop_front();
        if (got.result_kind !== want.result_kind)
          report_mismatch($sformatf("beat %0d result_kind %0d, want %0d",
                                    results_seen, got.result_kind, want.result_kind));
        if (got.word_value !== want.word_value)
          report_mismatch($sformatf("beat %0d word_value %h, want %h",
                                    results_seen, got.word_value, want.word_value));
        if (got.frame_status !== want.frame_status)
          report_mismatch($sformatf("beat %0d frame_status %0d, want %0d",
                                    results_seen, got.frame_status, want.frame_status));
        if (got.slave_address !== want.slave_address)
          report_mismatch($sformatf("beat %0d slave_address %h, want %h",
                                    results_seen, got.slave_address, want.slave_address));
        if (got.function_code !== want.function_code)
          report_mismatch($sformatf("beat %0d function_code %h, want %h",
                                    results_seen, got.function_code, want.function_code));
        if (got.word_count !== want.word_count)
          report_mismatch($sformatf("beat %0d word_count %0d, want %0d",
                                    results_seen, got.word_count, want.word_count));
        if (got.last !== want.last)
          report_mismatch($sformatf("beat %0d last %0d, want %0d",
                                    results_seen, got.last, want.last));
      end
    end
  end

  // watchdog: end the run if no channel moves for too long
  always @(posedge clk) begin
    if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready) ||
        (cfg_bus.valid && cfg_bus.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("timeout after %0d quiet cycles", quiet_cycles);
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    rx_plan_t   s;
    logic [1:0] mode;
    int         sent;
    rst_n              = 1'b0;
    in_bus.valid       = 1'b0;
    in_bus.rx_byte     = 8'h00;
    in_bus.frame_start = 1'b0;
    cfg_bus.valid      = 1'b0;
    cfg_bus.word_mode  = WM_RESET;
    mismatches         = 0;
    results_seen       = 0;
    quiet_cycles       = 0;
    hold_request       = 0;
    steady_in          = 1'b0;
    steady_out         = 1'b0;
    shadow_phase       = PH_ADDR;
    shadow_crc         = CRC_INIT;
    shadow_expect_len  = '0;
    shadow_seen        = '0;
    shadow_acc         = '0;
    shadow_pos         = '0;
    shadow_addr        = '0;
    shadow_func        = '0;
    shadow_crc_lo      = '0;
    shadow_words       = '0;
    shadow_mode        = WM_RESET;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    for (int i = 0; i < NUM_ROWS; i++) send_beat(DIRECTED_ROWS[i]);
    wait_idle();

    // leftover bytes carry frames across mode changes
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0:       mode = WM_BYTE;
        1:       mode = WM_WORD;
        2:       mode = WM_HALF;
        3:       mode = WM_SPARE;
        default: mode = 2'($urandom_range(0, 3));
      endcase
      set_word_mode(mode);
      steady_in  = (ph % 4 == 3) || (ph == 2);
      steady_out = (ph % 4 == 3);
      // stall the result side while bytes keep coming, so the input backs up
      if (ph == 2) hold_request = LONG_HOLD;
      sent = 0;
      while (sent < ITEMS_PER_PHASE) begin
        if (byte_plan.size() == 0) plan_frame();
        s = byte_plan.pop_front();
        if (s.frame_start || shadow_phase != PH_ADDR) sent++;
        send_beat(s);
      end
      wait_idle();
    end

    if (mismatches == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule

// ----- modbus_rtu_response_deframer_core.f -----
rtl/mrd_pkg.sv
rtl/mrd_ifs.sv
rtl/mrd_in_reg.sv
rtl/mrd_engine.sv
rtl/mrd_out_reg.sv
rtl/modbus_rtu_response_deframer_core.sv
rtl/mrd_checker.sv
tb/testbench.sv
